// File: hdl/mse_pkg.sv
// mse_pkg: shared types, opcode/funct codes and sizes for the MIPS subset
// execute unit. No dependencies; imported by every module in hdl/.
`timescale 1ns / 1ps

package mse_pkg;

	// Data memory geometry (word addressed, power of two)
	localparam int MEM_AW     = 10;
	localparam int DATA_WORDS = 1 << MEM_AW;
	// Width of the reported word index
	localparam int IDX_W      = 10;

	localparam int REG_AW     = 5;
	localparam int REGS       = 1 << REG_AW;
	localparam logic [REG_AW-1:0] SP_INDEX = REG_AW'(29);

	typedef enum logic [5:0] {
		OP_RTYPE = 6'd0,
		OP_ADDI  = 6'd8,
		OP_ADDIU = 6'd9,
		OP_SLTI  = 6'd10,
		OP_SLTIU = 6'd11,
		OP_LW    = 6'd35,
		OP_SW    = 6'd43
	} opcode_t;

	typedef enum logic [5:0] {
		FN_SLL  = 6'd0,
		FN_SRL  = 6'd2,
		FN_ADD  = 6'd32,
		FN_ADDU = 6'd33,
		FN_SUB  = 6'd34,
		FN_SUBU = 6'd35,
		FN_SLT  = 6'd42,
		FN_SLTU = 6'd43
	} funct_t;

	// Decoded and executed instruction, carried from execute into the result stage
	typedef struct packed {
		logic              reg_we;   // writes a nonzero register
		logic [REG_AW-1:0] dest;     // zero when nothing is written
		logic [31:0]       value;    // ALU result, zero for loads / no write
		logic              ld_wb;    // load whose data goes to a register
		logic              mem_rd;   // lw
		logic              mem_we;   // sw
		logic [MEM_AW-1:0] addr;     // word index, zero when no memory access
		logic [31:0]       data;     // store data (rt value)
		logic              bad;      // outside the supported subset
	} exec_t;

	// Register file contents right after reset
	function automatic logic [31:0] rf_reset_val(input logic [REG_AW-1:0] idx);
		logic [31:0] v;
		v = '0;
		if (idx == SP_INDEX) begin
			v = 32'(DATA_WORDS - 1);
		end
		return v;
	endfunction

endpackage

// File: hdl/mse_regfile.sv
// mse_regfile: 32 x 32 register file, two registered read ports with
// write-through, one write port, per-entry valid bits for the reset image.
// Depends on mse_pkg.
`timescale 1ns / 1ps

module mse_regfile
	import mse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [REG_AW-1:0] ra_a,
	input  logic [REG_AW-1:0] ra_b,
	output logic [31:0]       rdata_a,
	output logic [31:0]       rdata_b,
	input  logic              we,
	input  logic [REG_AW-1:0] wa,
	input  logic [31:0]       wd
);

	logic [31:0]     mem [REGS];
	logic [REGS-1:0] vld_q;
	logic [31:0]     rdata_a_q;
	logic [31:0]     rdata_b_q;
	logic [31:0]     look_a;
	logic [31:0]     look_b;

	// entry lookup: same-edge write wins, unwritten entries show reset image
	always_comb begin
		if (we && wa == ra_a) begin
			look_a = wd;
		end else if (vld_q[ra_a]) begin
			look_a = mem[ra_a];
		end else begin
			look_a = rf_reset_val(ra_a);
		end
		if (we && wa == ra_b) begin
			look_b = wd;
		end else if (vld_q[ra_b]) begin
			look_b = mem[ra_b];
		end else begin
			look_b = rf_reset_val(ra_b);
		end
	end

	// storage and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rdata_a_q <= look_a;
			rdata_b_q <= look_b;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[wa] <= 1'b1;
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

// File: hdl/mse_dmem.sv
// mse_dmem: word-addressed data memory, one read/write port with registered
// read data, and a clearing sweep after reset. Depends on mse_pkg.
`timescale 1ns / 1ps

module mse_dmem
	import mse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	output logic              busy,
	input  logic              rd_en,
	input  logic              we,
	input  logic [MEM_AW-1:0] addr,
	input  logic [31:0]       wd,
	output logic [31:0]       rdata
);

	logic [31:0]       mem [DATA_WORDS];
	logic [31:0]       rdata_q;
	logic [MEM_AW-1:0] clr_idx_q;
	logic              busy_q;

	// clear sweep: one word per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == MEM_AW'(DATA_WORDS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// array port
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (we) begin
			mem[addr] <= wd;
		end
		if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign busy  = busy_q;
	assign rdata = rdata_q;

endmodule

// File: hdl/mse_exec.sv
// mse_exec: decode and ALU for the supported subset, purely combinational.
// Takes the instruction and its operands, produces an exec_t. Depends on mse_pkg.
`timescale 1ns / 1ps

module mse_exec
	import mse_pkg::*;
(
	input  logic [31:0] instr,
	input  logic [31:0] vs,
	input  logic [31:0] vt,
	output exec_t       ex
);

	logic [5:0]        opcode;
	logic [5:0]        funct;
	logic [REG_AW-1:0] rt;
	logic [REG_AW-1:0] rd;
	logic [4:0]        shamt;
	logic [31:0]       simm;
	logic [31:0]       opb;
	logic [31:0]       sum;
	logic [31:0]       diff;
	logic              lt_s;
	logic              lt_u;
	logic              do_reg;
	logic              is_lw;
	logic              is_sw;
	logic              bad;
	logic              wr;
	logic [REG_AW-1:0] dest;
	logic [31:0]       value;

	// fields
	assign opcode = instr[31:26];
	assign rt     = instr[20:16];
	assign rd     = instr[15:11];
	assign shamt  = instr[10:6];
	assign funct  = instr[5:0];
	assign simm   = {{16{instr[15]}}, instr[15:0]};

	// shared datapath: second operand is rt for R type, immediate otherwise
	assign opb  = (opcode == OP_RTYPE) ? vt : simm;
	assign sum  = vs + opb;
	assign diff = vs - opb;
	assign lt_s = $signed(vs) < $signed(opb);
	assign lt_u = vs < opb;

	// decoder
	always_comb begin
		do_reg = 1'b0;
		is_lw  = 1'b0;
		is_sw  = 1'b0;
		bad    = 1'b0;
		dest   = rt;
		value  = '0;
		unique case (opcode) inside
			OP_RTYPE: begin
				dest   = rd;
				do_reg = 1'b1;
				unique case (funct) inside
					FN_SLL:          value = vt << shamt;
					FN_SRL:          value = vt >> shamt;
					FN_ADD, FN_ADDU: value = sum;
					FN_SUB, FN_SUBU: value = diff;
					FN_SLT:          value = {31'b0, lt_s};
					FN_SLTU:         value = {31'b0, lt_u};
					default: begin
						do_reg = 1'b0;
						bad    = 1'b1;
					end
				endcase
			end
			OP_ADDI, OP_ADDIU: begin
				value  = sum;
				do_reg = 1'b1;
			end
			OP_SLTI: begin
				value  = {31'b0, lt_s};
				do_reg = 1'b1;
			end
			OP_SLTIU: begin
				value  = {31'b0, lt_u};
				do_reg = 1'b1;
			end
			OP_LW: begin
				is_lw  = 1'b1;
				do_reg = 1'b1;
			end
			OP_SW: begin
				is_sw = 1'b1;
			end
			default: begin
				bad = 1'b1;
			end
		endcase
	end

	// register zero is never written; zero the unused fields
	assign wr        = do_reg && (dest != '0);
	assign ex.reg_we = wr;
	assign ex.dest   = wr ? dest : '0;
	assign ex.value  = (wr && !is_lw) ? value : '0;
	assign ex.ld_wb  = wr && is_lw;
	assign ex.mem_rd = is_lw;
	assign ex.mem_we = is_sw;
	assign ex.addr   = (is_lw || is_sw) ? sum[MEM_AW-1:0] : '0;
	assign ex.data   = vt;
	assign ex.bad    = bad;

endmodule

// File: hdl/mips_subset_execute_unit_top.sv
// mips_subset_execute_unit_top: two-stage execute unit for a MIPS32 integer
// subset. Uses mse_pkg, mse_regfile, mse_exec and mse_dmem.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid, in_stall, instruction       | into block
//   out     | out_valid, out_stall, reg_written,    | out of block
//           | dest_index, dest_value, mem_written,  |
//           | mem_word_index, unsupported           |
//
// One instruction per clock unless stalled; a beat moves from stage 1 to stage 2.
// Stage 1 holds the instruction with its register operands (registered read,
// forwarded from stage 2); stage 2 is the output register, fed for loads by the
// data memory's registered read port.
// After reset the data memory is swept to zero, with in_stall high throughout.
// Register writes retire when the result beat is taken; out_stall backs up into in_stall.
`timescale 1ns / 1ps

module mips_subset_execute_unit_top
	import mse_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         instruction,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                reg_written,
	output logic [4:0]          dest_index,
	output logic signed [31:0]  dest_value,
	output logic                mem_written,
	output logic [IDX_W-1:0]    mem_word_index,
	output logic                unsupported
);

	logic        valid_s1;
	logic [31:0] instr_s1;
	logic        valid_s2;
	exec_t       ex_s2;
	exec_t       ex_c;
	logic        in_accept;
	logic        out_accept;
	logic        adv_s1;
	logic        clr_busy;
	logic [31:0] rf_a;
	logic [31:0] rf_b;
	logic [31:0] vs;
	logic [31:0] vt;
	logic [31:0] wb_data;
	logic [31:0] mem_rdata;
	logic        rf_we;

	// handshake
	assign out_accept = valid_s2 && !out_stall;
	assign adv_s1     = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall   = clr_busy || (valid_s1 && !adv_s1);
	assign in_accept  = in_valid && !in_stall;

	// stage 1: instruction register
	always_ff @(posedge clk) begin
		if (in_accept) begin
			instr_s1 <= instruction;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// register file: read as the beat is taken, written as the result leaves
	assign wb_data = ex_s2.ld_wb ? mem_rdata : ex_s2.value;
	assign rf_we   = out_accept && ex_s2.reg_we;

	mse_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_accept),
		.ra_a    (instruction[25:21]),
		.ra_b    (instruction[20:16]),
		.rdata_a (rf_a),
		.rdata_b (rf_b),
		.we      (rf_we),
		.wa      (ex_s2.dest),
		.wd      (wb_data)
	);

	// forward the pending stage 2 write
	always_comb begin
		vs = rf_a;
		vt = rf_b;
		if (valid_s2 && ex_s2.reg_we && ex_s2.dest == instr_s1[25:21]) begin
			vs = wb_data;
		end
		if (valid_s2 && ex_s2.reg_we && ex_s2.dest == instr_s1[20:16]) begin
			vt = wb_data;
		end
	end

	mse_exec u_exec (
		.instr (instr_s1),
		.vs    (vs),
		.vt    (vt),
		.ex    (ex_c)
	);

	// data memory: accessed as stage 1 advances
	mse_dmem u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (clr_busy),
		.rd_en  (adv_s1 && ex_c.mem_rd),
		.we     (adv_s1 && ex_c.mem_we),
		.addr   (ex_c.addr),
		.wd     (ex_c.data),
		.rdata  (mem_rdata)
	);

	// stage 2: result register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ex_s2 <= ex_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_accept) begin
			valid_s2 <= 1'b0;
		end
	end

	// outputs
	assign out_valid      = valid_s2;
	assign reg_written    = ex_s2.reg_we;
	assign dest_index     = ex_s2.dest;
	assign dest_value     = $signed(wb_data);
	assign mem_written    = ex_s2.mem_we;
	assign mem_word_index = IDX_W'(ex_s2.addr);
	assign unsupported    = ex_s2.bad;

	// checks
	a_dest_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reg_written |-> dest_index != '0)
		else $error("register write reported for register zero");

	a_bad_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported |-> !reg_written && !mem_written
			&& dest_value == 0 && mem_word_index == '0)
		else $error("unsupported instruction left side effects");

	a_one_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reg_written |-> !mem_written)
		else $error("register and memory written by one instruction");

	a_load_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(dest_value))
		else $error("result value moved while stalled");

	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> in_stall)
		else $error("beat taken during memory clear");

endmodule
